[rtl/nlpc_pkg.sv]
// shared types, constants and prime-form helper functions for the pitch-class line reader
// no dependencies
package nlpc_pkg;

    localparam int MAX_DIGITS  = 4;
    localparam int DCNT_W      = $clog2(MAX_DIGITS + 2);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int NUM_PARTS   = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        logic [11:0] mask;
        logic        err;
    } line_rec_t;

    // (v * 10) mod 12 for v in 0..11
    function automatic logic [3:0] ten_mod12(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'd0, 4'd6:  r = 4'd0;
            4'd1, 4'd7:  r = 4'd10;
            4'd2, 4'd8:  r = 4'd8;
            4'd3, 4'd9:  r = 4'd6;
            4'd4, 4'd10: r = 4'd4;
            4'd5, 4'd11: r = 4'd2;
            default:     r = 4'd0;
        endcase
        return r;
    endfunction

    // running value mod 12 after appending one decimal digit
    function automatic logic [3:0] digit_step(input logic [3:0] v, input logic [3:0] d);
        logic [4:0] t;
        t = 5'(ten_mod12(v)) + 5'(d);
        if (t >= 5'd12) begin
            t = t - 5'd12;
        end
        return t[3:0];
    endfunction

    function automatic logic [11:0] rot12(input logic [11:0] s, input logic [3:0] i);
        logic [23:0] d;
        d = {s, s} << i;
        return d[23:12];
    endfunction

    function automatic logic [11:0] mirror12(input logic [11:0] s);
        logic [11:0] m;
        for (int i = 0; i < 12; i++) begin
            m[11 - i] = s[i];
        end
        return m;
    endfunction

    // larger key wins: narrower span first, then larger code; zero if no class on top
    function automatic logic [KEY_W-1:0] rot_key(input logic [11:0] r);
        logic [3:0] low;
        logic [3:0] span;
        low = 4'd11;
        for (int i = 11; i >= 0; i--) begin
            if (r[i]) begin
                low = 4'(i);
            end
        end
        span = 4'd11 - low;
        return r[11] ? {4'd15 - span, r} : '0;
    endfunction

    // best key over six consecutive rotations starting at base
    function automatic logic [KEY_W-1:0] best6(input logic [11:0] s, input logic [3:0] base);
        logic [KEY_W-1:0] best;
        logic [KEY_W-1:0] k;
        best = '0;
        for (int i = 0; i < 6; i++) begin
            k = rot_key(rot12(s, base + 4'(i)));
            if (k > best) begin
                best = k;
            end
        end
        return best;
    endfunction

endpackage

[rtl/nlpc_front.sv]
// character parser: tracks number, line and error state, emits one record per data line or empty line
// depends on nlpc_pkg
module nlpc_front import nlpc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       q_full,
    output logic       push,
    output line_rec_t  rec
);

    logic [11:0]       pitch_set_reg, pitch_set_next;
    logic [3:0]        val_reg, val_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              in_num_reg, in_num_next;
    logic              tok_reg, tok_next;
    logic              start_reg, start_next;
    logic              discard_reg, discard_next;
    logic              err_reg, err_next;

    logic        acc;
    logic        overlong;
    logic [11:0] class_bit;
    logic        is_digit;
    logic        is_sep;
    logic        take;

    assign s_ready   = !q_full;
    assign acc       = s_valid && s_ready;
    assign overlong  = dcnt_reg > DCNT_W'(MAX_DIGITS);
    assign class_bit = 12'h800 >> val_reg;
    assign is_digit  = s_char_in inside {[CH_ZERO:CH_NINE]};
    assign is_sep    = s_char_in inside {CH_COMMA, CH_SEMI, CH_SPACE, CH_TAB};

    always_comb begin
        pitch_set_next = pitch_set_reg;
        val_next       = val_reg;
        dcnt_next      = dcnt_reg;
        in_num_next    = in_num_reg;
        tok_next       = tok_reg;
        start_next     = start_reg;
        discard_next   = discard_reg;
        err_next       = err_reg;
        push           = 1'b0;
        rec.mask       = pitch_set_reg;
        rec.err        = err_reg;
        take           = 1'b1;

        if (acc && s_char_in != CH_CR) begin
            if (s_char_in == CH_LF) begin
                push = start_reg || tok_reg;
                if (start_reg) begin
                    rec.err = 1'b1;
                end else if (in_num_reg && !discard_reg) begin
                    // close the pending number
                    if (overlong) begin
                        rec.err = 1'b1;
                    end else begin
                        rec.mask = pitch_set_reg | class_bit;
                    end
                end
                pitch_set_next = '0;
                val_next       = '0;
                dcnt_next      = '0;
                in_num_next    = 1'b0;
                tok_next       = 1'b0;
                start_next     = 1'b1;
                discard_next   = 1'b0;
                err_next       = 1'b0;
            end else if (!discard_reg) begin
                if (start_reg) begin
                    start_next = 1'b0;
                    if (s_char_in inside {CH_STAR, CH_HASH}) begin
                        // comment line
                        discard_next = 1'b1;
                        tok_next     = 1'b0;
                        take         = 1'b0;
                    end else begin
                        tok_next = 1'b1;
                        if (s_char_in == CH_NUL) begin
                            err_next     = 1'b1;
                            discard_next = 1'b1;
                            take         = 1'b0;
                        end
                    end
                end
                if (take) begin
                    if (is_digit) begin
                        if (in_num_reg) begin
                            val_next = digit_step(val_reg, s_char_in[3:0]);
                            if (dcnt_reg <= DCNT_W'(MAX_DIGITS)) begin
                                dcnt_next = dcnt_reg + 1'b1;
                            end
                        end else begin
                            in_num_next = 1'b1;
                            val_next    = s_char_in[3:0];
                            dcnt_next   = DCNT_W'(1);
                        end
                    end else begin
                        if (in_num_reg) begin
                            if (overlong) begin
                                err_next     = 1'b1;
                                discard_next = 1'b1;
                            end else begin
                                pitch_set_next = pitch_set_reg | class_bit;
                            end
                            in_num_next = 1'b0;
                            dcnt_next   = '0;
                            val_next    = '0;
                        end
                        if (s_char_in == CH_NUL) begin
                            discard_next = 1'b1;
                        end else if (!is_sep) begin
                            err_next     = 1'b1;
                            discard_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_set_reg <= '0;
            val_reg       <= '0;
            dcnt_reg      <= '0;
            in_num_reg    <= 1'b0;
            tok_reg       <= 1'b0;
            start_reg     <= 1'b1;
            discard_reg   <= 1'b0;
            err_reg       <= 1'b0;
        end else begin
            pitch_set_reg <= pitch_set_next;
            val_reg       <= val_next;
            dcnt_reg      <= dcnt_next;
            in_num_reg    <= in_num_next;
            tok_reg       <= tok_next;
            start_reg     <= start_next;
            discard_reg   <= discard_next;
            err_reg       <= err_next;
        end
    end

endmodule

[rtl/nlpc_queue.sv]
// two-entry queue of line records between parser and prime-form pipeline
// depends on nlpc_pkg
module nlpc_queue import nlpc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  line_rec_t wr_rec,
    output logic      full,
    input  logic      pop,
    output logic      rd_valid,
    output line_rec_t rd_rec
);

    line_rec_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_rec   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

[rtl/nlpc_back.sv]
// prime-form pipeline: partial rotation search, final pick, output register
// depends on nlpc_pkg
module nlpc_back import nlpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  line_rec_t   q_rec,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pitch_mask,
    output logic [11:0] m_prime_form,
    output logic        m_format_error
);

    logic             s1_valid_reg, s1_valid_next;
    line_rec_t        s1_rec_reg;
    logic [KEY_W-1:0] s1_part_reg [NUM_PARTS];
    logic [KEY_W-1:0] part [NUM_PARTS];
    logic [11:0]      mirror;
    logic [KEY_W-1:0] best;

    logic        m_valid_reg, m_valid_next;
    logic [11:0] m_mask_reg;
    logic [11:0] m_prime_reg;
    logic        m_err_reg;

    logic out_adv;
    logic s1_load;

    assign out_adv = !m_valid_reg || m_ready;
    assign s1_load = !s1_valid_reg || out_adv;
    assign q_pop   = q_valid && s1_load;

    assign mirror  = mirror12(q_rec.mask);
    assign part[0] = best6(q_rec.mask, 4'd0);
    assign part[1] = best6(q_rec.mask, 4'd6);
    assign part[2] = best6(mirror, 4'd0);
    assign part[3] = best6(mirror, 4'd6);

    always_comb begin
        best = '0;
        for (int i = 0; i < NUM_PARTS; i++) begin
            if (s1_part_reg[i] > best) begin
                best = s1_part_reg[i];
            end
        end
    end

    assign s1_valid_next = s1_load ? q_valid : s1_valid_reg;
    assign m_valid_next  = out_adv ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_rec_reg  <= q_rec;
            s1_part_reg <= part;
        end
        if (out_adv && s1_valid_reg) begin
            m_mask_reg  <= s1_rec_reg.mask;
            m_prime_reg <= best[11:0];
            m_err_reg   <= s1_rec_reg.err;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pitch_mask   = m_mask_reg;
    assign m_prime_form   = m_prime_reg;
    assign m_format_error = m_err_reg;

endmodule

[rtl/note_line_pitch_class_prime_form.sv]
// pitch-class line reader: one character per cycle, one result per data line or empty line at its newline
// a line result passes through the queue, the search stage register and the output register in turn
// throughput: one character a cycle; input stalls only once four line results (two queued,
//   one in the search stage, one at the output) are held up by the result side
// reset: aresetn synchronous active low, clears parser state, queue and pipeline valids
// depends on nlpc_pkg, nlpc_front, nlpc_queue, nlpc_back
module note_line_pitch_class_prime_form import nlpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pitch_mask,
    output logic [11:0] m_prime_form,
    output logic        m_format_error
);

    logic      push;
    line_rec_t wr_rec;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    line_rec_t q_rec;

    nlpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .q_full    (q_full),
        .push      (push),
        .rec       (wr_rec)
    );

    nlpc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_rec   (wr_rec),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_rec   (q_rec)
    );

    nlpc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_rec          (q_rec),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pitch_mask   (m_pitch_mask),
        .m_prime_form   (m_prime_form),
        .m_format_error (m_format_error)
    );

    // queue is never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("record queue overflow");

    // prime form keeps the class count of the set
    a_same_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($countones(m_prime_form) == $countones(m_pitch_mask)))
        else $error("prime form class count differs from set");

    // a nonempty prime form starts on class 0
    a_prime_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_prime_form != 12'd0) |-> m_prime_form[11])
        else $error("prime form does not start on class 0");

    // a waiting result beat holds steady
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pitch_mask) &&
            $stable(m_prime_form) && $stable(m_format_error)))
        else $error("result beat changed while waiting");

endmodule

[tb/note_line_pitch_class_prime_form_test.sv]
`timescale 1ns / 100ps
// testbench for the pitch-class line reader: streams text lines and checks each line result
// depends on nlpc_pkg and note_line_pitch_class_prime_form
module note_line_pitch_class_prime_form_test import nlpc_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [11:0] mask;
        logic [11:0] prime;
        logic        err;
    } line_result_t;

    typedef enum {LINE_DATA, LINE_COMMENT, LINE_OVERLONG, LINE_STRAY, LINE_NOISE} line_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_in = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_pitch_mask;
    logic [11:0] m_prime_form;
    logic        m_format_error;

    // line parser state
    logic [11:0] seen_classes;
    int          number_mod12;
    int          digits_in_number;
    bit          reading_number;
    bit          data_line;
    bit          line_start;
    bit          dropping_line;
    bit          line_bad;

    line_result_t line_results_due[$];
    logic [7:0]   line_buf[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int stray_results = 0;
    int chars_sent = 0;
    int results_checked = 0;
    int error_results = 0;
    int comment_lines = 0;

    note_line_pitch_class_prime_form dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pitch_mask   (m_pitch_mask),
        .m_prime_form   (m_prime_form),
        .m_format_error (m_format_error)
    );

    always #4 aclk = ~aclk;

    // narrowest rotation with class 0 on top, over the set and its inversion; ties to larger code
    function automatic logic [11:0] prime_form_of(input logic [11:0] pcs);
        logic [1:0][11:0] cand;
        logic [11:0] rot;
        logic [11:0] best;
        int best_width;
        int low;
        best = '0;
        best_width = 99;
        cand[0] = pcs;
        for (int k = 0; k < 12; k++) begin
            cand[1][11 - k] = pcs[k];
        end
        for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < 12; i++) begin
                for (int k = 0; k < 12; k++) begin
                    rot[(k + i) % 12] = cand[m][k];
                end
                if (rot[11]) begin
                    low = 11;
                    for (int k = 11; k >= 0; k--) begin
                        if (rot[k]) begin
                            low = k;
                        end
                    end
                    if (11 - low < best_width || (11 - low == best_width && rot > best)) begin
                        best = rot;
                        best_width = 11 - low;
                    end
                end
            end
        end
        return best;
    endfunction

    function automatic void clear_line();
        seen_classes = '0;
        number_mod12 = 0;
        digits_in_number = 0;
        reading_number = 1'b0;
        data_line = 1'b0;
        line_start = 1'b1;
        dropping_line = 1'b0;
        line_bad = 1'b0;
    endfunction

    function automatic void close_number();
        if (digits_in_number > MAX_DIGITS) begin
            line_bad = 1'b1;
            dropping_line = 1'b1;
        end else begin
            seen_classes[11 - number_mod12] = 1'b1;
        end
        reading_number = 1'b0;
        digits_in_number = 0;
        number_mod12 = 0;
    endfunction

    function automatic bit is_separator(input logic [7:0] c);
        return c == CH_COMMA || c == CH_SEMI || c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // advance the parser by one character; emit is set when the line yields a result
    function automatic void parse_char(input logic [7:0] c, output bit emit,
                                       output line_result_t res);
        emit = 1'b0;
        res = '0;
        if (c == CH_CR) begin
            return;
        end
        if (c == CH_LF) begin
            if (line_start || data_line) begin
                if (!line_start && reading_number && !dropping_line) begin
                    close_number();
                end
                emit = 1'b1;
                res.mask = seen_classes;
                res.prime = prime_form_of(seen_classes);
                res.err = line_start ? 1'b1 : line_bad;
            end
            clear_line();
            return;
        end
        if (dropping_line) begin
            return;
        end
        if (line_start) begin
            line_start = 1'b0;
            if (c == CH_STAR || c == CH_HASH) begin
                dropping_line = 1'b1;
                data_line = 1'b0;
                return;
            end
            data_line = 1'b1;
            if (c == CH_NUL) begin
                line_bad = 1'b1;
                dropping_line = 1'b1;
                return;
            end
        end
        if (is_digit(c)) begin
            if (!reading_number) begin
                reading_number = 1'b1;
                digits_in_number = 0;
                number_mod12 = 0;
            end
            number_mod12 = (number_mod12 * 10 + int'(c - CH_ZERO)) % 12;
            if (digits_in_number <= MAX_DIGITS) begin
                digits_in_number++;
            end
        end else if (is_separator(c)) begin
            if (reading_number) begin
                close_number();
            end
        end else begin
            if (reading_number) begin
                close_number();
            end
            // a zero byte past the start drops the line quietly
            if (c != CH_NUL) begin
                line_bad = 1'b1;
            end
            dropping_line = 1'b1;
        end
    endfunction

    task automatic send_char(input logic [7:0] c);
        bit emit;
        line_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_char_in = c;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        chars_sent++;
        parse_char(c, emit, res);
        if (emit) begin
            line_results_due.push_back(res);
        end
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i]);
        end
    endtask

    task automatic send_buffer();
        while (line_buf.size() > 0) begin
            send_char(line_buf.pop_front());
        end
    endtask

    task automatic wait_results_drained();
        s_valid = 1'b0;
        wait (line_results_due.size() == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic buffer_char(input logic [7:0] c);
        if ($urandom_range(24) == 0) begin
            line_buf.push_back(CH_CR);
        end
        line_buf.push_back(c);
    endtask

    task automatic buffer_separators(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) begin
            case ($urandom_range(3))
                0: buffer_char(CH_COMMA);
                1: buffer_char(CH_SEMI);
                2: buffer_char(CH_SPACE);
                default: buffer_char(CH_TAB);
            endcase
        end
    endtask

    function automatic logic [7:0] pick_stray();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (is_digit(b) || is_separator(b) || b == CH_LF || b == CH_CR);
        return b;
    endfunction

    task automatic build_line(input line_kind_t kind);
        int n_nums;
        int bad_at;
        int n_dig;
        case (kind)
            LINE_COMMENT: begin
                comment_lines++;
                buffer_char($urandom_range(1) ? CH_STAR : CH_HASH);
                repeat ($urandom_range(10)) buffer_char(8'($urandom_range(32, 126)));
            end
            LINE_NOISE: begin
                repeat ($urandom_range(1, 12)) buffer_char(8'($urandom()));
            end
            default: begin
                n_nums = $urandom_range(kind == LINE_DATA ? 0 : 1, 6);
                bad_at = $urandom_range(0, n_nums > 0 ? n_nums - 1 : 0);
                for (int j = 0; j < n_nums; j++) begin
                    buffer_separators(j == 0 ? 0 : 1, j == 0 ? 2 : 3);
                    n_dig = (kind == LINE_OVERLONG && j == bad_at) ?
                            $urandom_range(MAX_DIGITS + 1, 8) : $urandom_range(1, MAX_DIGITS);
                    repeat (n_dig) buffer_char(CH_ZERO + 8'($urandom_range(9)));
                    if (kind == LINE_STRAY && j == bad_at) begin
                        buffer_char(pick_stray());
                    end
                end
                buffer_separators(0, 2);
            end
        endcase
        line_buf.push_back(CH_LF);
    endtask

    task automatic test_directed_lines();
        send_char(CH_LF);                                   // empty line
        send_text("#");                                     // comment line
        send_char(CH_LF);
        send_char(CH_NUL);                                  // zero byte at line start
        send_char(CH_LF);
        send_text("99999");                                 // overlong number
        send_char(CH_LF);
        send_text("7");                                     // carriage return, then high byte
        send_char(CH_CR);
        send_text(",");
        send_char(8'hFF);
        send_char(CH_LF);
        send_text("0");                                     // zero byte mid-line
        send_char(CH_NUL);
        send_text("5");
        send_char(CH_LF);
        send_text("\t; 11*");                               // star past line start is stray
        send_char(CH_LF);
        wait_results_drained();
    endtask

    task automatic test_random_text(input int idle_pct, input int stall_pct, input int n_chars);
        int start_count;
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start_count = chars_sent;
        while (chars_sent - start_count < n_chars) begin
            pick = $urandom_range(99);
            if (pick < 65) build_line(LINE_DATA);
            else if (pick < 72) build_line(LINE_COMMENT);
            else if (pick < 80) build_line(LINE_OVERLONG);
            else if (pick < 90) build_line(LINE_STRAY);
            else build_line(LINE_NOISE);
            send_buffer();
        end
        wait_results_drained();
    endtask

    // receiver holds off while short lines keep coming, so the result queue fills
    task automatic test_full_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_cycles = 300;
        @(negedge aclk);
        repeat (40) begin
            send_char(CH_ZERO + 8'($urandom_range(9)));
            send_char(CH_LF);
        end
        wait_results_drained();
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        line_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (line_results_due.size() == 0) begin
                stray_results++;
                if (mismatches + stray_results <= MAX_SHOWN) begin
                    $display("unexpected result beat: mask %h prime %h err %b",
                             m_pitch_mask, m_prime_form, m_format_error);
                end
            end else begin
                exp_res = line_results_due.pop_front();
                results_checked++;
                if (m_format_error) begin
                    error_results++;
                end
                if (m_pitch_mask !== exp_res.mask || m_prime_form !== exp_res.prime ||
                        m_format_error !== exp_res.err) begin
                    mismatches++;
                    if (mismatches + stray_results <= MAX_SHOWN) begin
                        $display("result %0d: mask exp %h got %h, prime exp %h got %h, err exp %b got %b",
                                 results_checked, exp_res.mask, m_pitch_mask,
                                 exp_res.prime, m_prime_form, exp_res.err, m_format_error);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        clear_line();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed_lines();
        test_random_text(0, 0, 450);
        test_random_text(82, 0, 450);
        test_random_text(0, 82, 450);
        test_random_text(38, 38, 450);
        test_full_backpressure();
        wait_results_drained();
        $display("sent %0d characters; checked %0d line results, %0d flagged as errors",
                 chars_sent, results_checked, error_results);
        $display("%0d comment lines, %0d mismatches, %0d unexpected beats, %0d left over",
                 comment_lines, mismatches, stray_results, line_results_due.size());
        if (mismatches == 0 && stray_results == 0 && line_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[note_line_pitch_class_prime_form.f]
rtl/nlpc_pkg.sv
rtl/nlpc_front.sv
rtl/nlpc_queue.sv
rtl/nlpc_back.sv
rtl/note_line_pitch_class_prime_form.sv
tb/note_line_pitch_class_prime_form_test.sv
